>>> rtl/core/ece_pkg.sv
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Shared widths, register indexes, the micro-op program of the curve
// sequencer, and the divider request and response types.
// ----------------------------------------------------------------------------
`default_nettype none

package ece_pkg;

   // Internal fixed point: signed values with 28 fraction bits.
   localparam int IQ  = 28;
   localparam int TOL = 32;
   localparam int DW  = 36;
   localparam int MW  = DW;
   localparam int PW  = 2 * MW;
   localparam int DVW = DW + IQ;

   localparam int AW      = 5;
   localparam int CW      = 32;
   localparam int COUNT_W = 10;

   localparam int DEF_FRACTION_BITS   = 16;
   localparam int DEF_NEWTON_STEPS    = 8;
   localparam int DEF_BISECTION_STEPS = 24;

   // Register indexes (byte address divided by four).
   localparam logic [2:0] REG_CURVE_MODE    = 3'd0;
   localparam logic [2:0] REG_CTRL_X_FIRST  = 3'd1;
   localparam logic [2:0] REG_CTRL_Y_FIRST  = 3'd2;
   localparam logic [2:0] REG_CTRL_X_SECOND = 3'd3;
   localparam logic [2:0] REG_CTRL_Y_SECOND = 3'd4;
   localparam logic [2:0] REG_STEP_COUNT    = 3'd5;
   localparam logic [2:0] REG_JUMP_POSITION = 3'd6;

   localparam logic [1:0] JUMP_END   = 2'd0;
   localparam logic [1:0] JUMP_START = 2'd1;
   localparam logic [1:0] JUMP_NONE  = 2'd2;
   localparam logic [1:0] JUMP_BOTH  = 2'd3;

   // Multiplier operand sources.
   localparam logic [3:0] SRC_T   = 4'd0;
   localparam logic [3:0] SRC_OM  = 4'd1;
   localparam logic [3:0] SRC_T2  = 4'd2;
   localparam logic [3:0] SRC_U   = 4'd3;
   localparam logic [3:0] SRC_V   = 4'd4;
   localparam logic [3:0] SRC_A   = 4'd5;
   localparam logic [3:0] SRC_B   = 4'd6;
   localparam logic [3:0] SRC_BMA = 4'd7;
   localparam logic [3:0] SRC_OMB = 4'd8;

   // Write-back destinations.
   localparam logic [2:0] DST_T2  = 3'd0;
   localparam logic [2:0] DST_U   = 3'd1;
   localparam logic [2:0] DST_V   = 3'd2;
   localparam logic [2:0] DST_ACC = 3'd3;
   localparam logic [2:0] DST_D   = 3'd4;

   localparam logic [1:0] SCALE_1 = 2'd0;
   localparam logic [1:0] SCALE_3 = 2'd1;
   localparam logic [1:0] SCALE_6 = 2'd2;

   localparam logic [3:0] UOP_CURVE_FIRST = 4'd0;
   localparam logic [3:0] UOP_CURVE_LAST  = 4'd6;
   localparam logic [3:0] UOP_SLOPE_FIRST = 4'd7;
   localparam logic [3:0] UOP_SLOPE_LAST  = 4'd10;

   typedef struct packed {
      logic [3:0] src_a;
      logic [3:0] src_b;
      logic [2:0] dst;
      logic       add;
      logic [1:0] scale;
   } uop_type;

   typedef struct packed {
      logic           start;
      logic [DVW-1:0] num;
      logic [MW-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [DVW-1:0] quo;
   } div_rsp_type;

   // The curve program fills T2 and U, which the slope program then reuses.
   function automatic uop_type uop_at(input logic [3:0] idx);
      uop_type u;
      case (idx)
         4'd0:    u = '{SRC_T,  SRC_T,   DST_T2,  1'b0, SCALE_1};
         4'd1:    u = '{SRC_OM, SRC_OM,  DST_U,   1'b0, SCALE_1};
         4'd2:    u = '{SRC_U,  SRC_T,   DST_V,   1'b0, SCALE_1};
         4'd3:    u = '{SRC_V,  SRC_A,   DST_ACC, 1'b0, SCALE_3};
         4'd4:    u = '{SRC_OM, SRC_T2,  DST_V,   1'b0, SCALE_1};
         4'd5:    u = '{SRC_V,  SRC_B,   DST_ACC, 1'b1, SCALE_3};
         4'd6:    u = '{SRC_T2, SRC_T,   DST_ACC, 1'b1, SCALE_1};
         4'd7:    u = '{SRC_U,  SRC_A,   DST_D,   1'b0, SCALE_3};
         4'd8:    u = '{SRC_OM, SRC_T,   DST_V,   1'b0, SCALE_1};
         4'd9:    u = '{SRC_V,  SRC_BMA, DST_D,   1'b1, SCALE_6};
         4'd10:   u = '{SRC_T2, SRC_OMB, DST_D,   1'b1, SCALE_3};
         default: u = '{SRC_T,  SRC_T,   DST_V,   1'b0, SCALE_1};
      endcase
      return u;
   endfunction

   // Product back to Q.28, rounded to nearest with ties away from zero.
   function automatic logic signed [DW-1:0] round_q(input logic signed [PW-1:0] p);
      logic [PW-1:0] m;
      logic [PW-1:0] r;
      m = p[PW-1] ? PW'(-p) : PW'(p);
      r = (m + (PW'(1) << (IQ - 1))) >> IQ;
      return p[PW-1] ? -$signed(r[DW-1:0]) : $signed(r[DW-1:0]);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/ece_mul.sv
// ----------------------------------------------------------------------------
// Easing curve evaluator multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_mul
   import ece_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic signed [MW-1:0] mul_a,
   input  wire logic signed [MW-1:0] mul_b,
   output logic signed [PW-1:0]      prod_ff
);

   logic signed [PW-1:0] prod_in;

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/ece_div.sv
// ----------------------------------------------------------------------------
// Easing curve evaluator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_div
   import ece_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int CNTW = $clog2(DVW + 1);

   logic [MW-1:0]   rem_ff, rem_in;
   logic [MW-1:0]   den_ff, den_in;
   logic [DVW-1:0]  quo_ff, quo_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [MW:0]     trial;
   logic [MW:0]     diff;
   logic            ge;

   assign trial = {rem_ff, quo_ff[DVW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = '0;
         den_in = div_req.den;
         quo_in = div_req.num;
         cnt_in = CNTW'(DVW);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[MW-1:0] : trial[MW-1:0];
         quo_in = {quo_ff[DVW-2:0], ge};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

`default_nettype wire

>>> rtl/core/easing_curve_evaluator_core.sv
// ----------------------------------------------------------------------------
// Easing curve evaluator
// Cubic Bezier and stepped easing of a clamped time sample.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the time sample is
// on req_time_in. The eased value appears on rsp_progress_out for exactly one
// cycle with rsp_valid high; the receiver cannot stall it.
// The registers are written through the APB port; the user must write them only
// while the block is idle, which the block itself does not enforce. The linear
// curve answers in the cycle after the request. Stepped mode passes through a
// multiply state and the bit-serial divider, or skips the divider for a single
// jump-none step. A Bezier curve evaluation runs its products one at a time on
// the one shared multiplier, each in an operand phase and a write-back phase,
// followed by a check state; a slope evaluation does the same, and each Newton
// quotient waits on the bit-serial divider.
// busy stays high for the whole evaluation, so one request is in flight.
// Reset is synchronous; it returns the sequencer to idle and the registers
// to a linear curve in Bezier mode with one jump-end step.
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_evaluator_core
   import ece_pkg::*;
#(
   parameter int FRACTION_BITS   = DEF_FRACTION_BITS,
   parameter int NEWTON_STEPS    = DEF_NEWTON_STEPS,
   parameter int BISECTION_STEPS = DEF_BISECTION_STEPS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [FRACTION_BITS+1:0] req_time_in,
   output logic                             busy,
   output logic                             rsp_valid,
   output logic signed [FRACTION_BITS+3:0]  rsp_progress_out,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [AW-1:0]               paddr,
   input  wire logic [CW-1:0]               pwdata,
   output logic [CW-1:0]                    prdata,
   output logic                             pready
);

   localparam int F  = FRACTION_BITS;
   localparam int SH = IQ - F;
   localparam int IW = $clog2(NEWTON_STEPS + 1);
   localparam int BW = $clog2(BISECTION_STEPS + 1);

   localparam logic [F:0]            XONE_X = (F+1)'(1) << F;
   localparam logic signed [F+2:0]   XONE_Y = (F+3)'(1) << F;
   localparam logic signed [DW-1:0]  IONE   = DW'(1) << IQ;
   localparam logic signed [DW-1:0]  LIM_P  = (DW'(1) << (F + 3)) - DW'(1);
   localparam logic signed [DW-1:0]  LIM_N  = -(DW'(1) << (F + 3));

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CURVE = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_SLOPE = 4'd3;
   localparam logic [3:0] S_SCHK  = 4'd4;
   localparam logic [3:0] S_NDIV  = 4'd5;
   localparam logic [3:0] S_SMUL  = 4'd6;
   localparam logic [3:0] S_SDIV  = 4'd7;
   localparam logic [3:0] S_SWAIT = 4'd8;

   localparam logic [1:0] P_NEWTON = 2'd0;
   localparam logic [1:0] P_BISECT = 2'd1;
   localparam logic [1:0] P_FINAL  = 2'd2;

   // Configuration registers.
   logic                  mode_ff;
   logic [F:0]            x1_ff, x2_ff;
   logic signed [F+2:0]   y1_ff, y2_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [1:0]            jump_ff;

   logic [3:0]            state_ff, state_in;
   logic [1:0]            purpose_ff, purpose_in;
   logic [3:0]            op_ff, op_in;
   logic                  phase_ff, phase_in;
   logic [IW-1:0]         iter_ff, iter_in;
   logic [BW-1:0]         bis_ff, bis_in;
   logic                  neg_ff, neg_in;
   logic [F:0]            tv_ff, tv_in;
   logic signed [DW-1:0]  t_ff, t_in, t2_ff, t2_in, u_ff, u_in, v_ff, v_in;
   logic signed [DW-1:0]  acc_ff, acc_in, d_ff, d_in, a_ff, a_in, b_ff, b_in;
   logic signed [DW-1:0]  x_ff, x_in, lo_ff, lo_in, hi_ff, hi_in, err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [F+3:0]   rsp_prog_ff, rsp_prog_in;

   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [PW-1:0]  prod_ff;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic [F:0]            tv;
   logic                  linear;
   logic signed [DW-1:0]  x1_q, x2_q, y1_q, y2_q, xq;
   logic signed [DW-1:0]  om, bma, omb;
   uop_type               uop;
   logic signed [DW-1:0]  w, sw, e, mid, nlo, nhi, res, fin;
   logic [DW-1:0]         emag, dmag, fmag, fr;
   logic signed [DVW+1:0] qs, tn;
   logic [COUNT_W-1:0]    cnt_eff;
   logic [COUNT_W:0]      step1, divv, stepc;
   logic                  err_near, do_final, do_bisect, do_finish;

   ece_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   ece_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Clamp of the time sample to zero..one.
   always_comb begin
      if (req_time_in[F+1]) begin
         tv = '0;
      end else if (req_time_in[F:0] > XONE_X) begin
         tv = XONE_X;
      end else begin
         tv = req_time_in[F:0];
      end
   end

   assign linear = (x1_ff == '0) && (y1_ff == '0) && (x2_ff == XONE_X) && (y2_ff == XONE_Y);
   assign x1_q   = $signed(DW'(x1_ff)) <<< SH;
   assign x2_q   = $signed(DW'(x2_ff)) <<< SH;
   assign y1_q   = DW'(y1_ff) <<< SH;
   assign y2_q   = DW'(y2_ff) <<< SH;
   assign xq     = $signed(DW'(tv)) <<< SH;
   assign om     = IONE - t_ff;
   assign bma    = b_ff - a_ff;
   assign omb    = IONE - b_ff;
   assign uop    = uop_at(op_ff);

   assign w  = round_q(prod_ff);
   always_comb begin
      case (uop.scale)
         SCALE_3: sw = w + (w <<< 1);
         SCALE_6: sw = (w <<< 2) + (w <<< 1);
         default: sw = w;
      endcase
   end

   assign e    = acc_ff - x_ff;
   assign emag = err_ff[DW-1] ? DW'(-err_ff) : DW'(err_ff);
   assign dmag = d_ff[DW-1] ? DW'(-d_ff) : DW'(d_ff);

   // Newton update: t minus the signed quotient, clamped to zero..one.
   assign qs = neg_ff ? -$signed({2'b00, div_rsp.quo}) : $signed({2'b00, div_rsp.quo});
   assign tn = (DVW+2)'(t_ff) - qs;

   // Final Q.28 to Q.F rounding, ties away from zero.
   assign fmag = acc_ff[DW-1] ? DW'(-acc_ff) : DW'(acc_ff);
   assign fr   = (fmag + (DW'(1) << (SH - 1))) >> SH;
   assign fin  = acc_ff[DW-1] ? -$signed(fr) : $signed(fr);

   // Stepped mode quantities.
   assign cnt_eff = (count_ff == '0) ? COUNT_W'(1) : count_ff;
   always_comb begin
      step1 = {1'b0, prod_ff[F+COUNT_W-1:F]};
      if (jump_ff inside {JUMP_START, JUMP_BOTH}) begin
         step1 = step1 + (COUNT_W+1)'(1);
      end
      case (jump_ff)
         JUMP_NONE: divv = {1'b0, cnt_eff} - (COUNT_W+1)'(1);
         JUMP_BOTH: divv = {1'b0, cnt_eff} + (COUNT_W+1)'(1);
         default:   divv = {1'b0, cnt_eff};
      endcase
      stepc = (step1 > divv) ? divv : step1;
   end

   always_comb begin
      state_in     = state_ff;
      purpose_in   = purpose_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      iter_in      = iter_ff;
      bis_in       = bis_ff;
      neg_in       = neg_ff;
      tv_in        = tv_ff;
      t_in         = t_ff;
      t2_in        = t2_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      x_in         = x_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      err_in       = err_ff;
      rsp_valid_in = 1'b0;
      rsp_prog_in  = rsp_prog_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;
      res          = '0;
      do_final     = 1'b0;
      do_bisect    = 1'b0;
      do_finish    = 1'b0;
      err_near     = (e > -DW'(TOL)) && (e < DW'(TOL));
      nlo          = lo_ff;
      nhi          = hi_ff;
      mid          = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               tv_in = tv;
               if (mode_ff) begin
                  state_in = S_SMUL;
               end else if (linear) begin
                  res       = $signed(DW'(tv));
                  do_finish = 1'b1;
               end else begin
                  x_in       = xq;
                  t_in       = xq;
                  a_in       = x1_q;
                  b_in       = x2_q;
                  iter_in    = '0;
                  purpose_in = P_NEWTON;
                  op_in      = UOP_CURVE_FIRST;
                  phase_in   = 1'b0;
                  state_in   = S_CURVE;
               end
            end
         end
         S_CURVE, S_SLOPE: begin
            if (!phase_ff) begin
               case (uop.src_a)
                  SRC_T:   mul_a = t_ff;
                  SRC_OM:  mul_a = om;
                  SRC_T2:  mul_a = t2_ff;
                  SRC_U:   mul_a = u_ff;
                  SRC_V:   mul_a = v_ff;
                  default: mul_a = t_ff;
               endcase
               case (uop.src_b)
                  SRC_T:   mul_b = t_ff;
                  SRC_OM:  mul_b = om;
                  SRC_T2:  mul_b = t2_ff;
                  SRC_A:   mul_b = a_ff;
                  SRC_B:   mul_b = b_ff;
                  SRC_BMA: mul_b = bma;
                  SRC_OMB: mul_b = omb;
                  default: mul_b = t_ff;
               endcase
               phase_in = 1'b1;
            end else begin
               case (uop.dst)
                  DST_T2:  t2_in  = sw;
                  DST_U:   u_in   = sw;
                  DST_ACC: acc_in = uop.add ? acc_ff + sw : sw;
                  DST_D:   d_in   = uop.add ? d_ff + sw : sw;
                  default: v_in   = sw;
               endcase
               phase_in = 1'b0;
               if ((state_ff == S_CURVE && op_ff == UOP_CURVE_LAST) ||
                   (state_ff == S_SLOPE && op_ff == UOP_SLOPE_LAST)) begin
                  state_in = (state_ff == S_CURVE) ? S_CHECK : S_SCHK;
               end else begin
                  op_in = op_ff + 4'd1;
               end
            end
         end
         S_CHECK: begin
            case (purpose_ff)
               P_NEWTON: begin
                  if (err_near) begin
                     do_final = 1'b1;
                  end else begin
                     err_in   = e;
                     op_in    = UOP_SLOPE_FIRST;
                     phase_in = 1'b0;
                     state_in = S_SLOPE;
                  end
               end
               P_BISECT: begin
                  if (err_near) begin
                     do_final = 1'b1;
                  end else begin
                     if (acc_ff < x_ff) begin
                        nlo = t_ff;
                     end else begin
                        nhi = t_ff;
                     end
                     mid   = (nlo + nhi) >>> 1;
                     lo_in = nlo;
                     hi_in = nhi;
                     t_in  = mid;
                     if (bis_ff == BW'(BISECTION_STEPS - 1)) begin
                        do_final = 1'b1;
                     end else begin
                        bis_in   = bis_ff + BW'(1);
                        op_in    = UOP_CURVE_FIRST;
                        phase_in = 1'b0;
                        state_in = S_CURVE;
                     end
                  end
               end
               default: begin
                  res       = fin;
                  do_finish = 1'b1;
               end
            endcase
         end
         S_SCHK: begin
            if ((d_ff > -DW'(TOL)) && (d_ff < DW'(TOL))) begin
               do_bisect = 1'b1;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DVW'(emag) << IQ;
               div_req.den   = dmag;
               neg_in        = err_ff[DW-1] ^ d_ff[DW-1];
               state_in      = S_NDIV;
            end
         end
         S_NDIV: begin
            if (div_rsp.done) begin
               if (tn < 0) begin
                  t_in = '0;
               end else if (tn > (DVW+2)'(IONE)) begin
                  t_in = IONE;
               end else begin
                  t_in = tn[DW-1:0];
               end
               if (iter_ff == IW'(NEWTON_STEPS - 1)) begin
                  do_bisect = 1'b1;
               end else begin
                  iter_in  = iter_ff + IW'(1);
                  op_in    = UOP_CURVE_FIRST;
                  phase_in = 1'b0;
                  state_in = S_CURVE;
               end
            end
         end
         S_SMUL: begin
            mul_a    = $signed(MW'(tv_ff));
            mul_b    = $signed(MW'(cnt_eff));
            state_in = S_SDIV;
         end
         S_SDIV: begin
            if (divv == '0) begin
               res       = '0;
               do_finish = 1'b1;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = (DVW'(stepc) << F) + DVW'(divv >> 1);
               div_req.den   = MW'(divv);
               state_in      = S_SWAIT;
            end
         end
         S_SWAIT: begin
            if (div_rsp.done) begin
               res       = $signed(div_rsp.quo[DW-1:0]);
               do_finish = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_bisect) begin
         t_in       = x_ff;
         lo_in      = '0;
         hi_in      = IONE;
         bis_in     = '0;
         purpose_in = P_BISECT;
         op_in      = UOP_CURVE_FIRST;
         phase_in   = 1'b0;
         state_in   = S_CURVE;
      end
      if (do_final) begin
         a_in       = y1_q;
         b_in       = y2_q;
         purpose_in = P_FINAL;
         op_in      = UOP_CURVE_FIRST;
         phase_in   = 1'b0;
         state_in   = S_CURVE;
      end
      if (do_finish) begin
         rsp_valid_in = 1'b1;
         if (res > LIM_P) begin
            rsp_prog_in = LIM_P[F+3:0];
         end else if (res < LIM_N) begin
            rsp_prog_in = LIM_N[F+3:0];
         end else begin
            rsp_prog_in = res[F+3:0];
         end
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         purpose_ff   <= P_NEWTON;
         op_ff        <= UOP_CURVE_FIRST;
         phase_ff     <= 1'b0;
         iter_ff      <= '0;
         bis_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         purpose_ff   <= purpose_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         iter_ff      <= iter_in;
         bis_ff       <= bis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      tv_ff       <= tv_in;
      t_ff        <= t_in;
      t2_ff       <= t2_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      acc_ff      <= acc_in;
      d_ff        <= d_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      x_ff        <= x_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      err_ff      <= err_in;
      rsp_prog_ff <= rsp_prog_in;
   end

   // Register file; control x values above one saturate on write.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         x1_ff    <= '0;
         y1_ff    <= '0;
         x2_ff    <= XONE_X;
         y2_ff    <= XONE_Y;
         count_ff <= COUNT_W'(1);
         jump_ff  <= JUMP_END;
      end else if (psel && penable && pwrite) begin
         case (paddr[AW-1:2])
            REG_CURVE_MODE:    mode_ff  <= pwdata[0];
            REG_CTRL_X_FIRST:  x1_ff    <= (pwdata[F:0] > XONE_X) ? XONE_X : pwdata[F:0];
            REG_CTRL_Y_FIRST:  y1_ff    <= $signed(pwdata[F+2:0]);
            REG_CTRL_X_SECOND: x2_ff    <= (pwdata[F:0] > XONE_X) ? XONE_X : pwdata[F:0];
            REG_CTRL_Y_SECOND: y2_ff    <= $signed(pwdata[F+2:0]);
            REG_STEP_COUNT:    count_ff <= pwdata[COUNT_W-1:0];
            REG_JUMP_POSITION: jump_ff  <= pwdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[AW-1:2])
         REG_CURVE_MODE:    prdata = CW'(mode_ff);
         REG_CTRL_X_FIRST:  prdata = CW'(x1_ff);
         REG_CTRL_Y_FIRST:  prdata = CW'(y1_ff);
         REG_CTRL_X_SECOND: prdata = CW'(x2_ff);
         REG_CTRL_Y_SECOND: prdata = CW'(y2_ff);
         REG_STEP_COUNT:    prdata = CW'(count_ff);
         REG_JUMP_POSITION: prdata = CW'(jump_ff);
         default:           prdata = '0;
      endcase
   end

   assign pready           = 1'b1;
   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_progress_out = rsp_prog_ff;

`ifndef ASSERT_OFF
   // An accepted request either starts an evaluation or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither started nor answered");

   // The result is delivered as the sequencer returns to idle.
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   // The divider only finishes while the sequencer waits on it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_NDIV || state_ff == S_SWAIT))
      else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

>>> verif/easing_curve_evaluator_core_tb.sv
// ----------------------------------------------------------------------------
// Easing curve evaluator testbench
// Drives time samples through the command port under several register
// settings, predicts each eased value with a fixed-point model of the curve
// solver and the stepped quantizer, and compares every response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module easing_curve_evaluator_core_tb;
   import ece_pkg::*;

   localparam int FB = DEF_FRACTION_BITS;
   localparam logic MODE_BEZIER = 1'b0;
   localparam logic MODE_STEPS  = 1'b1;
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam longint ONE_Q = 64'sd1 << IQ;
   localparam longint TOL_Q = TOL;
   localparam int DRAIN_CYCLES = 1200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic signed [FB+1:0] req_time_in = '0;
   logic busy;
   logic rsp_valid;
   logic signed [FB+3:0] rsp_progress_out;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [AW-1:0] paddr = '0;
   logic [CW-1:0] pwdata = '0;
   logic [CW-1:0] prdata;
   logic pready;

   easing_curve_evaluator_core dut (
      .clock(clock), .reset(reset), .start(start), .req_time_in(req_time_in),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_progress_out(rsp_progress_out),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the registers.
   logic   mode_sh;
   longint x1_sh, y1_sh, x2_sh, y2_sh;
   int     count_sh;
   logic [1:0] jump_sh;

   logic signed [FB+1:0] time_queue[$];
   logic signed [FB+3:0] progress_queue[$];
   int errors = 0;
   int burst_left = 8;
   int gap_left = 0;

   function automatic longint rnd_shift(longint p, int sh);
      longint m;
      m = (p < 0) ? -p : p;
      m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
      return (p < 0) ? -m : m;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return rnd_shift(a * b, IQ);
   endfunction

   function automatic longint bez_value(longint a, longint b, longint t);
      longint om, t2, p;
      om = ONE_Q - t;
      t2 = qmul(t, t);
      p = 3 * qmul(qmul(qmul(om, om), t), a);
      p += 3 * qmul(qmul(om, t2), b);
      return p + qmul(t2, t);
   endfunction

   function automatic longint bez_slope(longint a, longint b, longint t);
      longint om, d;
      om = ONE_Q - t;
      d = 3 * qmul(qmul(om, om), a);
      d += 6 * qmul(qmul(om, t), b - a);
      return d + 3 * qmul(qmul(t, t), ONE_Q - b);
   endfunction

   function automatic longint solve_param(longint a, longint b, longint x);
      longint t, lo, hi, err, d, v;
      t = x; lo = 0; hi = ONE_Q;
      for (int i = 0; i < DEF_NEWTON_STEPS; i++) begin
         err = bez_value(a, b, t) - x;
         if (((err < 0) ? -err : err) < TOL_Q) return t;
         d = bez_slope(a, b, t);
         // A nearly flat slope abandons Newton and restarts bisection.
         if (((d < 0) ? -d : d) < TOL_Q) break;
         t -= (err * ONE_Q) / d;
         if (t < 0) t = 0;
         if (t > ONE_Q) t = ONE_Q;
      end
      t = x;
      for (int i = 0; i < DEF_BISECTION_STEPS; i++) begin
         v = bez_value(a, b, t);
         if (((v - x < 0) ? x - v : v - x) < TOL_Q) return t;
         if (v < x) lo = t; else hi = t;
         t = (lo + hi) / 2;
      end
      return t;
   endfunction

   function automatic logic signed [FB+3:0] eased_progress(logic signed [FB+1:0] tin);
      longint tv, res, cnt, stp, dv, p, lim;
      tv = tin;
      lim = 64'sd1 << (FB + 3);
      if (tv < 0) tv = 0;
      if (tv > (64'sd1 << FB)) tv = 64'sd1 << FB;
      if (mode_sh == MODE_STEPS) begin
         cnt = (count_sh == 0) ? 1 : count_sh;
         stp = (tv * cnt) >>> FB;
         dv = cnt;
         if (jump_sh == JUMP_START || jump_sh == JUMP_BOTH) stp += 1;
         if (jump_sh == JUMP_NONE) dv = cnt - 1;
         else if (jump_sh == JUMP_BOTH) dv = cnt + 1;
         if (dv == 0) res = 0;
         else begin
            if (stp > dv) stp = dv;
            res = ((stp <<< FB) + dv / 2) / dv;
         end
      end else if (x1_sh == 0 && y1_sh == 0 && x2_sh == (64'sd1 << FB) &&
                   y2_sh == (64'sd1 << FB)) begin
         res = tv;
      end else begin
         p = solve_param(x1_sh <<< (IQ - FB), x2_sh <<< (IQ - FB), tv <<< (IQ - FB));
         res = rnd_shift(bez_value(y1_sh <<< (IQ - FB), y2_sh <<< (IQ - FB), p), IQ - FB);
      end
      if (res > lim - 1) res = lim - 1;
      if (res < -lim) res = -lim;
      return res[FB+3:0];
   endfunction

   task automatic append_time(logic signed [FB+1:0] val);
      time_queue = {time_queue, val};
   endtask

   task automatic append_progress(logic signed [FB+3:0] val);
      progress_queue = {progress_queue, val};
   endtask

   // Request acceptance and the prediction that goes with it.
   always @(posedge clock) begin
      logic signed [FB+3:0] pred;
      if (!reset && start && !busy) begin
         pred = eased_progress(time_queue.pop_front());
         append_progress(pred);
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         end
      end
   end

   always @(negedge clock) begin
      if (reset || gap_left > 0) begin
         if (!reset) gap_left--;
         start <= 1'b0;
      end else if (time_queue.size() > 0) begin
         start <= 1'b1;
         req_time_in <= time_queue[0];
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      logic signed [FB+3:0] want;
      if (!reset && rsp_valid) begin
         if (progress_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %0d", rsp_progress_out);
         end else begin
            want = progress_queue.pop_front();
            if (want !== rsp_progress_out) begin
               errors++;
               if (errors <= 10)
                  $display("progress_out mismatch: expected %0d, got %0d",
                           want, rsp_progress_out);
            end
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_CURVE_MODE:    mode_sh = val[0];
         REG_CTRL_X_FIRST:  x1_sh = (val[FB:0] > (1 << FB)) ? (1 << FB) : val[FB:0];
         REG_CTRL_Y_FIRST:  y1_sh = $signed(val[FB+2:0]);
         REG_CTRL_X_SECOND: x2_sh = (val[FB:0] > (1 << FB)) ? (1 << FB) : val[FB:0];
         REG_CTRL_Y_SECOND: y2_sh = $signed(val[FB+2:0]);
         REG_STEP_COUNT:    count_sh = val[COUNT_W-1:0];
         REG_JUMP_POSITION: jump_sh = val[1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (time_queue.size() > 0 || progress_queue.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_all(logic m, int x1, int y1, int x2, int y2, int cnt, int jp);
      write_reg(REG_CURVE_MODE, 32'(m));
      write_reg(REG_CTRL_X_FIRST, x1);
      write_reg(REG_CTRL_Y_FIRST, y1);
      write_reg(REG_CTRL_X_SECOND, x2);
      write_reg(REG_CTRL_Y_SECOND, y2);
      write_reg(REG_STEP_COUNT, cnt);
      write_reg(REG_JUMP_POSITION, jp);
   endtask

   function automatic int rand_time();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return $urandom_range(0, 1 << FB);
   endfunction

   function automatic int rand_y();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1 << FB);
         default: return $urandom_range(0, 3 << (FB - 1)) - (1 << (FB - 2));
      endcase
   endfunction

   initial begin
      mode_sh = MODE_BEZIER; x1_sh = 0; y1_sh = 0;
      x2_sh = 1 << FB; y2_sh = 1 << FB; count_sh = 1; jump_sh = JUMP_END;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Linear curve out of reset, time extremes and clamping.
      time_queue = '{18'sh20000, -18'sd1, 18'sd0, 18'sd1, 18'sd32768,
                     18'sd65535, 18'sd65536, 18'sd65537, 18'sd131071};
      drain();
      // Ease curve, then one jump-none step (zero divisor), then each jump kind.
      set_all(MODE_BEZIER, 16384, 6554, 16384, 65536, 1, JUMP_END);
      time_queue = '{18'sd0, 18'sd21845, 18'sd65536};
      drain();
      set_all(MODE_STEPS, 0, 0, 65536, 65536, 1, JUMP_NONE);
      time_queue = '{18'sd0, 18'sd65536};
      drain();
      for (int j = 0; j < 4; j++) begin
         set_all(MODE_STEPS, 0, 0, 65536, 65536, (j == 0) ? 0 : 1023, j);
         time_queue = '{18'sd0, 18'sd32768, 18'sd65536};
         drain();
      end
      // Out-of-range writes: x saturation, extreme y, and an unmapped index.
      set_all(MODE_BEZIER, 131071, -262144, 131071, 262143, 1000, JUMP_END);
      write_reg(REG_UNUSED, 32'hffff_ffff);
      time_queue = '{18'sd1000, 18'sd40000};
      drain();

      for (int ph = 0; ph < 60; ph++) begin
         if ($urandom_range(0, 5) == 0)
            set_all(MODE_BEZIER, 0, 0, 65536, 65536, $urandom, $urandom);
         else
            set_all(1'($urandom_range(0, 1)),
                    ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 65536),
                    rand_y(),
                    ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 65536),
                    rand_y(), $urandom, $urandom);
         if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom);
         repeat (25) append_time(18'(rand_time()));
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (progress_queue.size() > 0) errors++;
      if (errors == 0) $display("easing_curve_evaluator_core_tb passed");
      else $display("easing_curve_evaluator_core_tb failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("easing_curve_evaluator_core_tb failed");
      $finish;
   end

endmodule
